### rtl/ps2sc_pkg.sv
// Shared types and constants for the PS/2 scan code set 2 parser.
// Holds the byte codes, the event kinds and the packed result word.
// No dependencies.
`default_nettype none

package ps2sc_pkg;

  localparam logic [7:0] BYTE_EXT     = 8'hE0;
  localparam logic [7:0] BYTE_WIDE    = 8'hE1;
  localparam logic [7:0] BYTE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_SHIFT   = 8'h12;

  typedef enum logic [2:0] {
    KIND_UNKNOWN  = 3'd0,
    KIND_PRESS    = 3'd1,
    KIND_RELEASE  = 3'd2,
    KIND_XPRESS   = 3'd3,
    KIND_XRELEASE = 3'd4,
    KIND_WPRESS   = 3'd5,
    KIND_WRELEASE = 3'd6
  } kind_t;

  // Result word as it appears on the output tdata, lowest field last.
  typedef struct packed {
    logic [2:0]  pad;
    logic        translate_request;
    logic        shift_held;
    logic [15:0] key_code;
    kind_t       event_kind;
  } event_t;

  localparam int EventBits = $bits(event_t);

endpackage

`default_nettype wire

### rtl/ps2sc_decode.sv
// Phase tracking and event assembly for scan code set 2 byte streams.
// Depends on ps2sc_pkg for byte codes, event kinds and the result word.
`default_nettype none

module ps2sc_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic [7:0]           rx_byte,
  output logic                      emit,
  output ps2sc_pkg::event_t         result
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_EXT       = 4'd1,
    PH_EXT_REL   = 4'd2,
    PH_WIDE      = 4'd3,
    PH_WIDE_HI   = 4'd4,
    PH_WREL      = 4'd5,
    PH_WREL_SKIP = 4'd6,
    PH_WREL_HI   = 4'd7,
    PH_REL       = 4'd8
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        held_low_code, held_low_code_next;
  logic              shift_flag, shift_flag_next;
  ps2sc_pkg::kind_t  kind;
  logic [15:0]       code;
  logic              xlate;

  always_comb begin
    phase_next         = phase;
    held_low_code_next = held_low_code;
    kind               = ps2sc_pkg::KIND_UNKNOWN;
    code               = {8'h00, rx_byte};
    emit               = 1'b0;
    case (phase)
      PH_EXT: begin
        if (rx_byte == ps2sc_pkg::BYTE_RELEASE) begin
          phase_next = PH_EXT_REL;
        end else begin
          phase_next = PH_IDLE;
          kind       = ps2sc_pkg::KIND_XPRESS;
          emit       = 1'b1;
        end
      end
      PH_EXT_REL: begin
        phase_next = PH_IDLE;
        kind       = ps2sc_pkg::KIND_XRELEASE;
        emit       = 1'b1;
      end
      PH_WIDE: begin
        if (rx_byte == ps2sc_pkg::BYTE_RELEASE) begin
          phase_next = PH_WREL;
        end else begin
          held_low_code_next = rx_byte;
          phase_next         = PH_WIDE_HI;
        end
      end
      PH_WIDE_HI: begin
        phase_next = PH_IDLE;
        kind       = ps2sc_pkg::KIND_WPRESS;
        code       = {rx_byte, held_low_code};
        emit       = 1'b1;
      end
      PH_WREL: begin
        held_low_code_next = rx_byte;
        phase_next         = PH_WREL_SKIP;
      end
      PH_WREL_SKIP: begin
        phase_next = PH_WREL_HI;
      end
      PH_WREL_HI: begin
        phase_next = PH_IDLE;
        kind       = ps2sc_pkg::KIND_WRELEASE;
        code       = {rx_byte, held_low_code};
        emit       = 1'b1;
      end
      PH_REL: begin
        phase_next = PH_IDLE;
        kind       = ps2sc_pkg::KIND_RELEASE;
        emit       = 1'b1;
      end
      default: begin
        // Idle, and any unused phase code, start a new sequence here.
        phase_next = PH_IDLE;
        if (rx_byte == ps2sc_pkg::BYTE_EXT) begin
          phase_next = PH_EXT;
        end else if (rx_byte == ps2sc_pkg::BYTE_WIDE) begin
          phase_next = PH_WIDE;
        end else if (rx_byte == ps2sc_pkg::BYTE_RELEASE) begin
          phase_next = PH_REL;
        end else if (rx_byte[7]) begin
          kind = ps2sc_pkg::KIND_UNKNOWN;
          emit = 1'b1;
        end else begin
          kind = ps2sc_pkg::KIND_PRESS;
          emit = 1'b1;
        end
      end
    endcase
  end

  // An extended release of the shift code also sets the flag; an extended
  // press leaves it alone.
  always_comb begin
    shift_flag_next = shift_flag;
    xlate           = 1'b0;
    if (emit) begin
      if (code == {8'h00, ps2sc_pkg::CODE_SHIFT}) begin
        if (kind inside {ps2sc_pkg::KIND_PRESS, ps2sc_pkg::KIND_XRELEASE,
                         ps2sc_pkg::KIND_WPRESS, ps2sc_pkg::KIND_WRELEASE}) begin
          shift_flag_next = 1'b1;
        end else if (kind == ps2sc_pkg::KIND_RELEASE) begin
          shift_flag_next = 1'b0;
        end
      end else if (kind == ps2sc_pkg::KIND_PRESS) begin
        xlate = 1'b1;
      end
    end
  end

  always_comb begin
    result                   = '0;
    result.event_kind        = kind;
    result.key_code          = code;
    result.shift_held        = shift_flag_next;
    result.translate_request = xlate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held_low_code <= 8'h00;
      shift_flag    <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      held_low_code <= held_low_code_next;
      shift_flag    <= shift_flag_next;
    end
  end

`ifndef SYNTH
  a_release_after_prefix: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_REL |=> phase == PH_IDLE)
    else $error("release phase did not return to idle");

  a_skip_then_high: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_WREL_SKIP |=> phase == PH_WREL_HI)
    else $error("wide release skip byte not followed by high code phase");

  a_no_emit_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WIDE || phase == PH_WREL || phase == PH_WREL_SKIP) |-> !emit)
    else $error("event emitted in the middle of a wide sequence");
`endif

endmodule

`default_nettype wire

### rtl/ps2sc_out_reg.sv
// Result register for the parser's output stream.
// Depends on ps2sc_pkg for the packed result word.
`default_nettype none

module ps2sc_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire ps2sc_pkg::event_t  load_data,
  output logic                    ready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output ps2sc_pkg::event_t       m_tdata
);

  // The register frees up in the same cycle that its word is taken.
  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      m_tdata <= load_data;
    end
  end

endmodule

`default_nettype wire

### rtl/ps2_set2_scancode_parser.sv
// PS/2 scan code set 2 parser: byte stream in, key event words out.
// Depends on ps2sc_pkg, ps2sc_decode and ps2sc_out_reg.
//
// Usage:
//   Keyboard bytes enter on s_tvalid/s_tready/s_tdata, one byte per word.
//   Key events leave on m_tvalid/m_tready/m_tdata, one word per finished
//   event. Prefix bytes (E0, E1, F0) and the inner bytes of a wide code give
//   no output word; they only advance the parse phase.
//   A byte accepted from s_tdata lands in the input register; its event is
//   then loaded into the result register, which raises m_tvalid, once that
//   register is ready to take it.
//   Throughput is one byte per cycle while m_tready is high, set by the
//   single phase register that each byte updates.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more byte; s_tready falls once both are full.
//   Reset clears the parse phase, the held low code and the shift flag, and
//   empties both registers.
`default_nettype none

module ps2_set2_scancode_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [2:0] event_kind, [18:3] key_code,
                                      // [19] shift_held, [20] translate_request
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               out_ready;
  logic               proceed;
  logic               emit;
  ps2sc_pkg::event_t  result;
  ps2sc_pkg::event_t  out_word;

  assign proceed  = in_valid && out_ready;
  assign s_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  ps2sc_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (proceed),
    .rx_byte (in_byte),
    .emit    (emit),
    .result  (result)
  );

  ps2sc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (proceed && emit),
    .load_data (result),
    .ready     (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (out_word)
  );

  assign m_tdata = out_word[ps2sc_pkg::EventBits-1:0];

`ifndef SYNTH
  a_translate_plain_press: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_word.translate_request |->
      out_word.event_kind == ps2sc_pkg::KIND_PRESS &&
      out_word.key_code != {8'h00, ps2sc_pkg::CODE_SHIFT})
    else $error("translate request on an event that is not a plain press");

  a_shift_release_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_word.event_kind == ps2sc_pkg::KIND_RELEASE &&
      out_word.key_code == {8'h00, ps2sc_pkg::CODE_SHIFT} |-> !out_word.shift_held)
    else $error("shift still held after shift release");

  a_narrow_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_word.event_kind != ps2sc_pkg::KIND_WPRESS &&
      out_word.event_kind != ps2sc_pkg::KIND_WRELEASE |-> out_word.key_code[15:8] == 8'h00)
    else $error("high code byte set on a single byte event");

  a_unknown_high_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_word.event_kind == ps2sc_pkg::KIND_UNKNOWN |->
      out_word.key_code[7])
    else $error("unknown event with a code below 0x80");
`endif

endmodule

`default_nettype wire
